/* src/gbfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types, constants and channel payloads of the nearest free slot search.
// ----------------------------------------------------------------------------
package gbfs_pkg;

    localparam int GRID_X_DEF    = 64;
    localparam int GRID_Y_DEF    = 64;
    localparam int MAX_SLOTS_DEF = 1024;

    localparam int POS_W  = 6;
    localparam int KIND_W = 3;
    localparam int SLOT_W = 10;

    localparam logic [KIND_W-1:0] KIND_SLOT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ROAD = 3'd4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BUSY  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [KIND_W-1:0] cell_kind;
        logic [SLOT_W-1:0] slot_number;
        logic              busy_req;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] result_slot;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       init_step;   // zero one map and busy entry after reset
        logic       load_req;    // capture request, start point
        logic       write_map;   // write cell at request position
        logic       write_busy;  // write busy flag
        logic       clr_step;    // clear one visited mark, advance counter
        logic       seed;        // enqueue start cell
        logic       pop;         // read queue head
        logic       pop_take;    // latch popped cell
        logic       nb_read;     // read neighbour at direction counter
        logic       nb_eval;     // evaluate neighbour data
        logic       id_eval;     // evaluate busy flag of slot id
        logic       push;        // enqueue neighbour / mark visited
        logic       dir_next;    // advance direction
        logic       dir_clear;   // restart direction
        logic       set_found;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic clr_done;
        logic queue_empty;
        logic dir_last;
        logic nb_is_free_slot_cand;
        logic nb_is_road_new;
        logic slot_free;
        logic pass2;
    } sts_t;

endpackage
`default_nettype wire

/* src/gbfs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface gbfs_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/gbfs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* src/gbfs_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_datapath
// Map, busy and visited memories, walk queue and neighbour arithmetic.
// ----------------------------------------------------------------------------
module gbfs_datapath
    import gbfs_pkg::*;
#(
    parameter int GRID_X    = GRID_X_DEF,
    parameter int GRID_Y    = GRID_Y_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire req_t  req,
    input  wire ctl_t  ctl,
    output sts_t       sts,
    output rsp_t       rsp
);
    localparam int CELLS  = GRID_X * GRID_Y;
    localparam int CW     = $clog2(CELLS);
    localparam int XW     = $clog2(GRID_X) + 1;
    localparam int YW     = $clog2(GRID_Y) + 1;
    localparam int SW     = $clog2(MAX_SLOTS);
    localparam int QW     = $clog2(CELLS + 2);
    localparam int INIT_N = (CELLS > MAX_SLOTS) ? CELLS : MAX_SLOTS;
    localparam int IW     = $clog2(INIT_N + 1);

    // request and walk registers
    req_t            req_reg;
    logic [XW-1:0]   cx_reg;
    logic [YW-1:0]   cy_reg;
    logic [1:0]      dir_reg;
    logic            pass_reg;
    logic [QW-1:0]   head_reg, tail_reg;
    logic [CW:0]     clr_reg;
    logic [IW-1:0]   init_reg;
    logic            nb_in_reg;
    logic [CW-1:0]   nb_cell_reg;
    logic [XW-1:0]   nb_x_reg;
    logic [YW-1:0]   nb_y_reg;
    logic [SLOT_W-1:0] id_reg;
    logic            road_new_reg;
    logic            cand_reg;
    rsp_t            rsp_reg;

    // neighbour coordinates, one below zero wraps to the top and is out of grid
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          n_in;
    logic [CW-1:0] n_cell;
    logic          start_in;
    logic [CW-1:0] start_cell;

    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        case (dir_reg)
            2'd0:    nx = cx_reg - XW'(1);
            2'd1:    ny = cy_reg + YW'(1);
            2'd2:    nx = cx_reg + XW'(1);
            default: ny = cy_reg - YW'(1);
        endcase
        n_in   = (32'(nx) < GRID_X) && (32'(ny) < GRID_Y);
        n_cell = CW'(32'(nx) * GRID_Y + 32'(ny));
        start_in   = (32'(req_reg.pos_x) < GRID_X) && (32'(req_reg.pos_y) < GRID_Y);
        start_cell = CW'(32'(req_reg.pos_x) * GRID_Y + 32'(req_reg.pos_y));
    end

    // clearing pass after reset covers map cells and busy flags
    logic init_map;
    logic init_busy;
    assign init_map  = ctl.init_step && (32'(init_reg) < CELLS);
    assign init_busy = ctl.init_step && (32'(init_reg) < MAX_SLOTS);

    // map memories: zeroed after reset, written by map beats, read for neighbours
    logic               map_we;
    logic [CW-1:0]      map_addr;
    logic [KIND_W-1:0]  kind_wd;
    logic [SLOT_W-1:0]  id_wd;
    logic [KIND_W-1:0]  kind_rd;
    logic [SLOT_W-1:0]  id_rd;
    assign map_we   = (ctl.write_map && start_in) || init_map;
    assign map_addr = ctl.init_step ? init_reg[CW-1:0]
                    : ctl.write_map ? start_cell : n_cell;
    assign kind_wd  = ctl.init_step ? '0 : req_reg.cell_kind;
    assign id_wd    = ctl.init_step ? '0 : req_reg.slot_number;

    gbfs_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_kind (
        .clk(clk), .we(map_we), .addr(map_addr),
        .wdata(kind_wd), .rdata(kind_rd)
    );
    gbfs_ram #(.WIDTH(SLOT_W), .DEPTH(CELLS)) u_id (
        .clk(clk), .we(map_we), .addr(map_addr),
        .wdata(id_wd), .rdata(id_rd)
    );

    // busy flags: zeroed after reset, written by busy beats, read with slot id
    logic          busy_we;
    logic [SW-1:0] busy_addr;
    logic          busy_wd;
    logic          busy_rd;
    assign busy_we   = (ctl.write_busy && (32'(req_reg.slot_number) < MAX_SLOTS))
                       || init_busy;
    assign busy_addr = ctl.init_step  ? init_reg[SW-1:0]
                     : ctl.write_busy ? SW'(req_reg.slot_number) : SW'(id_reg);
    assign busy_wd   = ctl.init_step ? 1'b0 : req_reg.busy_req;

    gbfs_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_busy (
        .clk(clk), .we(busy_we), .addr(busy_addr),
        .wdata(busy_wd), .rdata(busy_rd)
    );

    // visited marks: cleared by sweep, read with neighbour, set on seed and push
    logic          vis_we;
    logic [CW-1:0] vis_addr;
    logic          vis_wd;
    logic          vis_rd;
    always_comb
    begin
        vis_we   = 1'b0;
        vis_wd   = 1'b0;
        vis_addr = n_cell;
        if (ctl.clr_step)
        begin
            vis_we   = 1'b1;
            vis_addr = clr_reg[CW-1:0];
        end
        else if (ctl.seed)
        begin
            vis_we   = start_in;
            vis_wd   = 1'b1;
            vis_addr = start_cell;
        end
        else if (ctl.push)
        begin
            vis_we   = 1'b1;
            vis_wd   = 1'b1;
            vis_addr = nb_cell_reg;
        end
    end

    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
        .clk(clk), .we(vis_we), .addr(vis_addr),
        .wdata(vis_wd), .rdata(vis_rd)
    );

    // walk queue of coordinates, start may lie out of grid so keep full width
    logic                q_we;
    logic [QW-1:0]       q_addr;
    logic [XW+YW-1:0]    q_wd, q_rd;
    always_comb
    begin
        q_we   = ctl.seed || ctl.push;
        q_addr = q_we ? tail_reg : head_reg;
        q_wd   = ctl.seed ? {XW'(req_reg.pos_x), YW'(req_reg.pos_y)}
                          : {nb_x_reg, nb_y_reg};
    end

    gbfs_ram #(.WIDTH(XW+YW), .DEPTH(CELLS+1)) u_queue (
        .clk(clk), .we(q_we), .addr(q_addr[$clog2(CELLS+1)-1:0]),
        .wdata(q_wd), .rdata(q_rd)
    );

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            clr_reg  <= '0;
            init_reg <= '0;
            dir_reg  <= '0;
            pass_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            if (ctl.init_step)
            begin
                init_reg <= init_reg + IW'(1);
            end
            if (ctl.load_req)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                clr_reg  <= '0;
                rsp_reg  <= '0;
            end
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + (CW+1)'(1);
            end
            if (ctl.seed || ctl.push)
            begin
                tail_reg <= tail_reg + QW'(1);
            end
            if (ctl.pop)
            begin
                head_reg <= head_reg + QW'(1);
            end
            if (ctl.dir_clear)
            begin
                dir_reg  <= '0;
                pass_reg <= 1'b0;
            end
            else if (ctl.dir_next)
            begin
                dir_reg <= dir_reg + 2'd1;
                if (dir_reg == 2'd3)
                begin
                    pass_reg <= ~pass_reg;
                end
            end
            if (ctl.set_found)
            begin
                rsp_reg.found       <= 1'b1;
                rsp_reg.result_slot <= id_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_reg <= req;
        end
        if (ctl.pop_take)
        begin
            cx_reg <= q_rd[XW+YW-1:YW];
            cy_reg <= q_rd[YW-1:0];
        end
        if (ctl.nb_read)
        begin
            nb_in_reg   <= n_in;
            nb_cell_reg <= n_cell;
            nb_x_reg    <= nx;
            nb_y_reg    <= ny;
        end
        if (ctl.nb_eval)
        begin
            id_reg       <= id_rd;
            cand_reg     <= nb_in_reg && (kind_rd == KIND_SLOT)
                            && (32'(id_rd) < MAX_SLOTS);
            road_new_reg <= nb_in_reg && (kind_rd == KIND_ROAD) && !vis_rd;
        end
    end

    assign sts.init_done            = (init_reg == IW'(INIT_N));
    assign sts.clr_done             = (clr_reg == (CW+1)'(CELLS));
    assign sts.queue_empty          = (head_reg == tail_reg);
    assign sts.dir_last             = (dir_reg == 2'd3);
    assign sts.nb_is_free_slot_cand = cand_reg;
    assign sts.nb_is_road_new       = road_new_reg;
    assign sts.slot_free            = !busy_rd;
    assign sts.pass2                = pass_reg;
    assign rsp = rsp_reg;

    // queue never overruns its storage
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(tail_reg) <= CELLS + 1)
        else $error("walk queue overrun");
    // head never passes tail
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    // a found result carries an in-range id
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_found |=> (32'(rsp_reg.result_slot) < MAX_SLOTS))
        else $error("found slot id out of range");
endmodule
`default_nettype wire

/* src/gbfs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Sequencer for map writes, busy updates and the breadth-first query.
// ----------------------------------------------------------------------------
module gbfs_ctrl
    import gbfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire cmd_t in_cmd,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);
    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_DISP  = 12'b000000000100,
        S_CLR   = 12'b000000001000,
        S_SEED  = 12'b000000010000,
        S_POP   = 12'b000000100000,
        S_TAKE  = 12'b000001000000,
        S_NBRD  = 12'b000010000000,
        S_NBEV  = 12'b000100000000,
        S_DEC   = 12'b001000000000,
        S_BUSY  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cmd_reg   <= CMD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                cmd_reg <= in_cmd;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_INIT:
            begin
                if (sts.init_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.init_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                case (cmd_reg)
                    CMD_WRITE:
                    begin
                        ctl.write_map = 1'b1;
                        state_next    = S_OUT;
                    end
                    CMD_BUSY:
                    begin
                        ctl.write_busy = 1'b1;
                        state_next     = S_OUT;
                    end
                    CMD_QUERY: state_next = S_CLR;
                    default:   state_next = S_OUT;
                endcase
            end
            S_CLR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_SEED;
                end
                else
                begin
                    ctl.clr_step = 1'b1;
                end
            end
            S_SEED:
            begin
                ctl.seed   = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sts.queue_empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.pop    = 1'b1;
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                ctl.pop_take  = 1'b1;
                ctl.dir_clear = 1'b1;
                state_next    = S_NBRD;
            end
            S_NBRD:
            begin
                ctl.nb_read = 1'b1;
                state_next  = S_NBEV;
            end
            S_NBEV:
            begin
                ctl.nb_eval = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                if (!sts.pass2 && sts.nb_is_free_slot_cand)
                begin
                    ctl.id_eval = 1'b1;
                    state_next  = S_BUSY;
                end
                else
                begin
                    if (sts.pass2 && sts.nb_is_road_new)
                    begin
                        ctl.push = 1'b1;
                    end
                    ctl.dir_next = 1'b1;
                    state_next   = (sts.pass2 && sts.dir_last) ? S_POP : S_NBRD;
                end
            end
            S_BUSY:
            begin
                if (sts.slot_free)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    ctl.dir_next = 1'b1;
                    state_next   = S_NBRD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // one beat in, one beat out
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready)
        else $error("no return to idle after result");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_found |-> !sts.pass2)
        else $error("slot found during road pass");
endmodule
`default_nettype wire

/* src/grid_bfs_nearest_free_slot.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bfs_nearest_free_slot
// Grid map with slot busy flags and a breadth-first nearest free slot query.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one beat per command (map write, busy update, query)
//   out : exactly one beat per command, found and result_slot
//   Map writes and busy updates do their write in the dispatch state, then
//   offer their result in the output state.
//   A query first clears the visited marks, one cell a cycle, then walks the
//   queue: each popped cell is read and taken, then each neighbour is read,
//   evaluated and decided on in each of two passes, with a busy check for
//   each slot candidate in the first pass and a final check that sees the
//   queue empty. Each store sits in a single-port memory.
//   One command at a time; the next beat is taken after the result leaves.
//   After reset a clearing pass zeroes the map, slot ids and busy flags, one
//   entry a cycle, with in ready low; control state resets directly.
//   While the receiver stalls, the result holds and no input is taken.
// ----------------------------------------------------------------------------
module grid_bfs_nearest_free_slot
    import gbfs_pkg::*;
#(
    parameter int GRID_X    = GRID_X_DEF,
    parameter int GRID_Y    = GRID_Y_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbfs_if.sink      in_ch,
    gbfs_if.source    out_ch
);
    ctl_t ctl;
    sts_t sts;
    rsp_t rsp;

    gbfs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_cmd(cmd_t'(in_ch.data.cmd)),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .ctl(ctl)
    );

    gbfs_datapath #(
        .GRID_X(GRID_X), .GRID_Y(GRID_Y), .MAX_SLOTS(MAX_SLOTS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_ch.data),
        .ctl(ctl), .sts(sts), .rsp(rsp)
    );

    assign out_ch.data = rsp;
endmodule
`default_nettype wire
